FILE: rtl/core/nsl_pkg.sv
// shared types and constants for the newton square root lanes block
package nsl_pkg;

  localparam int LANES         = 8;
  localparam int FRACTION_BITS = 28;
  localparam int WORD_W        = 32;
  localparam int THR_W         = 29;
  localparam int ITER_W        = 8;
  localparam int ADDR_W        = 4;

  localparam logic [WORD_W-1:0] ONE_FIX      = WORD_W'(1) << FRACTION_BITS;
  localparam logic [WORD_W-1:0] GUESS_RESET  = 32'd268435456;
  localparam logic [THR_W-1:0]  THR_RESET    = 29'd2684;
  localparam logic [ITER_W-1:0] ITER_RESET   = 8'd64;

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_GUESS     = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_MAX_ITER  = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_SQ,
    LS_XP,
    LS_CHK,
    LS_XG3,
    LS_UPD,
    LS_ROOT,
    LS_DONE
  } lane_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] value_0;
    logic [WORD_W-1:0] value_1;
    logic [WORD_W-1:0] value_2;
    logic [WORD_W-1:0] value_3;
    logic [WORD_W-1:0] value_4;
    logic [WORD_W-1:0] value_5;
    logic [WORD_W-1:0] value_6;
    logic [WORD_W-1:0] value_7;
    logic [LANES-1:0]  lane_valid;
  } arg_t;

  typedef struct packed {
    logic [WORD_W-1:0] root_0;
    logic [WORD_W-1:0] root_1;
    logic [WORD_W-1:0] root_2;
    logic [WORD_W-1:0] root_3;
    logic [WORD_W-1:0] root_4;
    logic [WORD_W-1:0] root_5;
    logic [WORD_W-1:0] root_6;
    logic [WORD_W-1:0] root_7;
    logic [LANES-1:0]  converged_mask;
  } res_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic              done;
    logic              conv;
    logic [WORD_W-1:0] root;
  } lane_res_t;

  typedef struct packed {
    logic [WORD_W-1:0] guess;
    logic [THR_W-1:0]  threshold;
    logic [ITER_W-1:0] max_iter;
  } cfg_t;

  // fixed-point product, truncated and saturated to one word
  function automatic logic [WORD_W-1:0] fmul(input logic [WORD_W-1:0] a,
                                             input logic [WORD_W-1:0] b);
    logic [2*WORD_W-1:0]               full;
    logic [2*WORD_W-FRACTION_BITS-1:0] hi;
    full = (2*WORD_W)'(a) * (2*WORD_W)'(b);
    hi   = full[2*WORD_W-1:FRACTION_BITS];
    return (|hi[2*WORD_W-FRACTION_BITS-1:WORD_W]) ? '1 : hi[WORD_W-1:0];
  endfunction

endpackage

FILE: rtl/core/newton_sqrt_lanes.sv
// top level: config registers, eight newton lanes and the output merge
// usage:
//   arg carries eight unsigned q4.28 operands and a lane valid mask, taken
//   when arg_valid and arg_ready are both high. res carries eight q4.28
//   roots and the converged mask, taken when res_valid and res_ready are high.
//   the apb port sets the start guess, the error threshold and the step cap;
//   write it only while no request is in flight.
// timing:
//   all eight lanes run at once, each on its own multiplier. an error check
//   steps through the sq, xp and chk states and a newton update through xg3
//   and upd; the result is loaded once every lane is done and the output
//   register is free (each lane stops after at most max_iterations updates).
//   one request is in flight at a time; arg_ready returns the cycle after
//   the result is loaded into the output register.
// reset:
//   rst is synchronous; it empties the lanes and the output register and
//   loads the register defaults (guess 1.0, threshold 2684, cap 64).
// stall:
//   a result held by a low res_ready does not block the next request, but
//   that request finishes only once the output register is free.
module newton_sqrt_lanes
  import nsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              arg_valid,
  output logic              arg_ready,
  input  arg_t              arg,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t              cfg;
  logic              busy;
  logic              start;
  logic              take;
  logic              cfg_wr;
  reg_index_t        reg_sel;
  logic [WORD_W-1:0] values [LANES];
  lane_res_t         lane_res [LANES];

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.guess     <= GUESS_RESET;
      cfg.threshold <= THR_RESET;
      cfg.max_iter  <= ITER_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_GUESS:     cfg.guess     <= pwdata;
        REG_THRESHOLD: cfg.threshold <= pwdata[THR_W-1:0];
        REG_MAX_ITER:  cfg.max_iter  <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GUESS:     prdata = cfg.guess;
      REG_THRESHOLD: prdata = 32'(cfg.threshold);
      REG_MAX_ITER:  prdata = 32'(cfg.max_iter);
      default:       prdata = '0;
    endcase
  end

  assign arg_ready = !busy;
  assign start     = arg_valid && arg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (take) begin
      busy <= 1'b0;
    end
  end

  assign values[0] = arg.value_0;
  assign values[1] = arg.value_1;
  assign values[2] = arg.value_2;
  assign values[3] = arg.value_3;
  assign values[4] = arg.value_4;
  assign values[5] = arg.value_5;
  assign values[6] = arg.value_6;
  assign values[7] = arg.value_7;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    nsl_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .start       (start),
      .active      (arg.lane_valid[i]),
      .x_in        (values[i]),
      .cfg         (cfg),
      .release_res (take),
      .res         (lane_res[i])
    );
  end

  nsl_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lane_res  (lane_res),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .take      (take)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("lanes not marked busy after a request");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |-> busy)
    else $error("lane results merged with no request in flight");

  a_take_frees: assert property (@(posedge clk) disable iff (rst)
    take |=> arg_ready && res_valid)
    else $error("merge did not free the lanes and load the output");

  a_out_from_take: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(take))
    else $error("result appeared without a merge");

endmodule

FILE: rtl/core/nsl_lane.sv
// one newton inverse square root lane with a shared multiplier
module nsl_lane
  import nsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              active,
  input  logic [WORD_W-1:0] x_in,
  input  cfg_t              cfg,
  input  logic              release_res,
  output lane_res_t         res
);

  lane_state_t state, state_next;

  logic [WORD_W-1:0] x, g, gg, prod, g3, root;
  logic [ITER_W-1:0] steps;
  logic              conv;

  logic [WORD_W-1:0] mul_a, mul_b, fm;
  logic [WORD_W-1:0] err;
  logic              in_tol;
  logic              at_cap;
  logic [WORD_W+1:0] t3w;
  logic [WORD_W-1:0] t3, diff;

  assign fm = fmul(mul_a, mul_b);

  assign err    = (prod >= ONE_FIX) ? prod - ONE_FIX : ONE_FIX - prod;
  assign in_tol = err <= WORD_W'(cfg.threshold);
  assign at_cap = steps == cfg.max_iter;

  assign t3w  = {2'b00, g} + {1'b0, g, 1'b0};
  assign t3   = (|t3w[WORD_W+1:WORD_W]) ? '1 : t3w[WORD_W-1:0];
  assign diff = (t3 > prod) ? t3 - prod : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      LS_IDLE: begin
        if (start) begin
          state_next = active ? LS_SQ : LS_DONE;
        end
      end
      LS_SQ:   state_next = LS_XP;
      LS_XP:   state_next = LS_CHK;
      LS_CHK:  state_next = (in_tol || at_cap) ? LS_ROOT : LS_XG3;
      LS_XG3:  state_next = LS_UPD;
      LS_UPD:  state_next = LS_SQ;
      LS_ROOT: state_next = LS_DONE;
      LS_DONE: begin
        if (release_res) begin
          state_next = LS_IDLE;
        end
      end
      default: state_next = LS_IDLE;
    endcase
  end

  // multiplier operand selection per step
  always_comb begin
    mul_a = g;
    mul_b = g;
    unique case (state)
      LS_SQ:   begin mul_a = g;  mul_b = g;  end
      LS_XP:   begin mul_a = gg; mul_b = x;  end
      LS_CHK:  begin mul_a = gg; mul_b = g;  end
      LS_XG3:  begin mul_a = x;  mul_b = g3; end
      LS_ROOT: begin mul_a = x;  mul_b = g;  end
      default: begin mul_a = g;  mul_b = g;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      LS_IDLE: begin
        if (start) begin
          x     <= x_in;
          g     <= cfg.guess;
          steps <= '0;
          root  <= '0;
          conv  <= 1'b1;
        end
      end
      LS_SQ:  gg   <= fm;
      LS_XP:  prod <= fm;
      LS_CHK: begin
        g3   <= fm;
        conv <= in_tol;
      end
      LS_XG3: prod <= fm;
      LS_UPD: begin
        g     <= {1'b0, diff[WORD_W-1:1]};
        steps <= steps + 1'b1;
      end
      LS_ROOT: root <= fm;
      default: ;
    endcase
  end

  assign res.done = state == LS_DONE;
  assign res.conv = conv;
  assign res.root = root;

endmodule

FILE: rtl/core/nsl_merge.sv
// collects the lane results into the registered output request
module nsl_merge
  import nsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lane_res_t lane_res [LANES],
  input  logic      res_ready,
  output logic      res_valid,
  output res_t      res,
  output logic      take
);

  logic [LANES-1:0] done_vec;
  logic [LANES-1:0] conv_vec;
  res_t             res_next;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      done_vec[i] = lane_res[i].done;
      conv_vec[i] = lane_res[i].conv;
    end
  end

  assign take = (&done_vec) && (!res_valid || res_ready);

  always_comb begin
    res_next.root_0         = lane_res[0].root;
    res_next.root_1         = lane_res[1].root;
    res_next.root_2         = lane_res[2].root;
    res_next.root_3         = lane_res[3].root;
    res_next.root_4         = lane_res[4].root;
    res_next.root_5         = lane_res[5].root;
    res_next.root_6         = lane_res[6].root;
    res_next.root_7         = lane_res[7].root;
    res_next.converged_mask = conv_vec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

FILE: bench/newton_sqrt_lanes_tb.sv
// testbench for newton_sqrt_lanes: random and directed lane requests checked against a predictor
module newton_sqrt_lanes_tb;
  import nsl_pkg::*;

  typedef logic [0:LANES-1][WORD_W-1:0] lane_words_t;

  typedef struct {
    logic [31:0] guess;
    logic [31:0] thr;
    logic [31:0] cap;
    int          count;
    logic [31:0] lo;
    logic [31:0] hi;
  } phase_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 1300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              arg_valid = 1'b0;
  logic              arg_ready;
  arg_t              arg = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  res_t              res;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // copy of the register file as the predictor sees it
  logic [WORD_W-1:0] cfg_guess     = GUESS_RESET;
  logic [THR_W-1:0]  cfg_threshold = THR_RESET;
  logic [ITER_W-1:0] cfg_cap       = ITER_RESET;

  arg_t pending_requests[$];
  res_t expected_roots[$];
  int   mismatches = 0;

  newton_sqrt_lanes DUT (
    .clk(clk), .rst(rst),
    .arg_valid(arg_valid), .arg_ready(arg_ready), .arg(arg),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // q4.28 product, truncated, saturated to one word
  function automatic logic [WORD_W-1:0] qmul(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [63:0] p;
    p = {32'b0, a} * {32'b0, b};
    p = p >> FRACTION_BITS;
    return (p[63:32] != 0) ? '1 : p[31:0];
  endfunction

  function automatic bit close_enough(logic [WORD_W-1:0] x, logic [WORD_W-1:0] g);
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] err;
    p   = qmul(qmul(g, g), x);
    err = (p >= ONE_FIX) ? p - ONE_FIX : ONE_FIX - p;
    return err <= {3'b0, cfg_threshold};
  endfunction

  function automatic logic [WORD_W-1:0] newton_update(logic [WORD_W-1:0] x,
                                                      logic [WORD_W-1:0] g);
    logic [33:0]       g3;
    logic [WORD_W-1:0] tri_g;
    logic [WORD_W-1:0] xg3;
    logic [WORD_W-1:0] d;
    g3    = {2'b0, g} * 34'd3;
    tri_g = (g3[33:32] != 0) ? '1 : g3[31:0];
    xg3   = qmul(x, qmul(qmul(g, g), g));
    // guess is unsigned, so a negative difference clamps at zero
    d     = (tri_g > xg3) ? tri_g - xg3 : '0;
    return d >> 1;
  endfunction

  function automatic res_t predict_roots(arg_t a);
    lane_words_t       vals;
    lane_words_t       roots;
    logic [LANES-1:0]  mask;
    logic [LANES-1:0]  conv;
    logic [WORD_W-1:0] g;
    int                steps;
    bit                done;
    {vals, mask} = a;
    conv = '0;
    for (int i = 0; i < LANES; i++) begin
      if (!mask[i]) begin
        roots[i] = '0;
        conv[i]  = 1'b1;
      end else begin
        g     = cfg_guess;
        steps = 0;
        done  = close_enough(vals[i], g);
        while (!done && steps < int'(cfg_cap)) begin
          g     = newton_update(vals[i], g);
          steps = steps + 1;
          done  = close_enough(vals[i], g);
        end
        conv[i]  = done;
        roots[i] = qmul(vals[i], g);
      end
    end
    return res_t'({roots, conv});
  endfunction

  function automatic arg_t uniform_request(logic [WORD_W-1:0] w, logic [LANES-1:0] m);
    lane_words_t vals;
    for (int i = 0; i < LANES; i++) vals[i] = w;
    return arg_t'({vals, m});
  endfunction

  // mostly operands inside the convergence range of the phase, some noise and corners
  function automatic arg_t random_request(logic [31:0] lo, logic [31:0] hi);
    lane_words_t      vals;
    logic [LANES-1:0] m;
    int               pick;
    for (int i = 0; i < LANES; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 74) begin
        vals[i] = $urandom_range(hi, lo);
      end else if (pick < 90) begin
        vals[i] = $urandom;
      end else begin
        case ($urandom_range(0, 4))
          0: vals[i] = '0;
          1: vals[i] = 32'd1;
          2: vals[i] = '1;
          3: vals[i] = ONE_FIX;
          default: vals[i] = ONE_FIX + 32'd1;
        endcase
      end
    end
    m = ($urandom_range(0, 9) < 7) ? '1 : LANES'($urandom);
    return arg_t'({vals, m});
  endfunction

  task automatic set_register(reg_index_t idx, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GUESS:     cfg_guess = data;
      REG_THRESHOLD: cfg_threshold = data[THR_W-1:0];
      REG_MAX_ITER:  cfg_cap = data[ITER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || arg_valid || expected_roots.size() != 0)
      @(negedge clk);
  endtask

  // sender: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      arg_valid <= 1'b0;
    end else if (!arg_valid || arg_ready) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        arg_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        arg       <= pending_requests.pop_front();
        arg_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        arg_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern in windows, plus one long hold-off
  int  mode_left = 0;
  int  stall_mode = 0;
  int  hold_left = 0;
  int  roots_taken = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) roots_taken <= roots_taken + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else if (!long_hold_done && roots_taken == 30) begin
        hold_left      <= LONG_HOLD;
        long_hold_done <= 1'b1;
        res_ready      <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left  <= $urandom_range(20, 80);
          stall_mode <= $urandom_range(0, 2);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: res_ready <= 1'b1;
          1: res_ready <= ($urandom_range(0, 3) != 0);
          default: res_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: predict on request, compare on result
  res_t             want;
  lane_words_t      got_roots;
  lane_words_t      want_roots;
  logic [LANES-1:0] got_mask;
  logic [LANES-1:0] want_mask;

  always @(posedge clk) begin
    if (!rst) begin
      if (arg_valid && arg_ready) expected_roots.push_back(predict_roots(arg));
      if (res_valid && res_ready) begin
        if (expected_roots.size() == 0) begin
          $error("result with no request outstanding: %h", res);
          mismatches = mismatches + 1;
        end else begin
          want = expected_roots.pop_front();
          {got_roots, got_mask}   = res;
          {want_roots, want_mask} = want;
          for (int i = 0; i < LANES; i++) begin
            if (got_roots[i] !== want_roots[i]) begin
              $error("root_%0d: expected %h, got %h", i, want_roots[i], got_roots[i]);
              mismatches = mismatches + 1;
            end
          end
          if (got_mask !== want_mask) begin
            $error("converged_mask: expected %h, got %h", want_mask, got_mask);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (arg_valid && arg_ready) || (res_valid && res_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  phase_t      plan [0:6];
  lane_words_t mixed;

  initial begin
    plan[0] = '{GUESS_RESET, THR_RESET, ITER_RESET, 650, 32'h0100_0000, 32'h2E00_0000};
    // zero threshold: only exact hits converge
    plan[1] = '{32'h0800_0000, 32'h0, 32'd12, 250, 32'h0400_0000, 32'hB000_0000};
    // threshold written with every bit set, upper bits dropped by the register
    plan[2] = '{32'h1000_0000, 32'hFFFF_FFFF, 32'd255, 150, 32'h0100_0000, 32'h2E00_0000};
    plan[3] = '{32'hFFFF_FFFF, 32'h1000_0000, 32'd255, 150, 32'h0000_1000, 32'h0030_0000};
    plan[4] = '{32'h0, 32'd2684, 32'd1, 150, 32'h0100_0000, 32'h2E00_0000};
    plan[5] = '{32'h1000_0000, 32'd1, 32'hFFFF_FFFF, 150, 32'h0100_0000, 32'h2E00_0000};
    plan[6] = '{32'h0B50_0000, 32'd2684, 32'd32, 200, 32'h0100_0000, 32'h5000_0000};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed requests on the reset registers
    mixed = {32'h4000_0000, 32'h0400_0000, 32'h2000_0000, 32'h0800_0000,
             32'h3000_0000, 32'h0000_0001, 32'h0FFF_FFFF, 32'h1000_0001};
    pending_requests.push_back(uniform_request(ONE_FIX, 8'hFF));
    pending_requests.push_back(uniform_request(32'h0, 8'hFF));
    pending_requests.push_back(uniform_request(32'hFFFF_FFFF, 8'hFF));
    pending_requests.push_back(uniform_request(32'h1234_5678, 8'h00));
    pending_requests.push_back(arg_t'({mixed, 8'hFF}));
    pending_requests.push_back(arg_t'({mixed, 8'hA5}));
    pending_requests.push_back(uniform_request(32'h5555_5555, 8'h55));
    pending_requests.push_back(uniform_request(32'hAAAA_AAAA, 8'hAA));
    pending_requests.push_back(arg_t'({mixed, 8'h01}));
    pending_requests.push_back(arg_t'({mixed, 8'h80}));
    wait_drained();

    // zero step cap: only lanes already within threshold converge
    set_register(REG_MAX_ITER, 32'h0);
    pending_requests.push_back(arg_t'({mixed, 8'hFF}));
    pending_requests.push_back(uniform_request(ONE_FIX, 8'hFF));
    wait_drained();

    foreach (plan[p]) begin
      set_register(REG_GUESS, plan[p].guess);
      set_register(REG_THRESHOLD, plan[p].thr);
      set_register(REG_MAX_ITER, plan[p].cap);
      for (int n = 0; n < plan[p].count; n++)
        pending_requests.push_back(random_request(plan[p].lo, plan[p].hi));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/nsl_pkg.sv
rtl/core/nsl_lane.sv
rtl/core/nsl_merge.sv
rtl/core/newton_sqrt_lanes.sv
bench/newton_sqrt_lanes_tb.sv
